// File: src/per_flow_aging_priority_scheduler_assert.svh
// Assertion macros used by the checker file.
`ifndef PER_FLOW_AGING_PRIORITY_SCHEDULER_ASSERT_SVH
`define PER_FLOW_AGING_PRIORITY_SCHEDULER_ASSERT_SVH

// Implication checked on every clock unless reset is low.
`define PFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define PFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pfas_pkg.sv
// ----------------------------------------------------------------------------
// pfas_pkg
// Types, constants and codes of the per-flow aging priority scheduler.
// ----------------------------------------------------------------------------
package pfas_pkg;

  localparam int FLOWS_DEF      = 16;
  localparam int FIFO_DEPTH_DEF = 8;
  localparam int CMD_W          = 2;
  localparam int FLOW_W         = 4;
  localparam int TAG_W          = 16;
  localparam int PRI_W          = 8;
  localparam int TIME_W         = 32;
  localparam int PERIOD_W       = 16;
  localparam int STATUS_W       = 2;
  localparam int WAIT_W         = 24;
  localparam int SCORE_W        = 25;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd5000;

  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PICK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // latch input item
    logic rd_head;   // issue head read for latched flow
    logic rd_tail;   // write new entry at tail
    logic snap;      // compute candidate score from read data
    logic scan_clr;  // reset scan
    logic scan_step; // compare one flow
    logic rd_best;   // read head of best flow
    logic grant;     // pop best flow
    logic rel;       // mark flow idle
    logic done;      // load result register
  } pfas_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic full;      // enqueue target full or out of range
    logic in_range;  // latched flow below FLOWS
    logic scan_last; // last flow under compare
    logic found;     // at least one candidate seen
  } pfas_sts_t;

endpackage

// File: src/per_flow_aging_priority_scheduler.sv
// ----------------------------------------------------------------------------
// per_flow_aging_priority_scheduler
// Per-flow request FIFOs with an aging priority pick.
// ----------------------------------------------------------------------------
// channel | ports                                         | dir
// in      | in_valid/in_ready, in_cmd, in_flow, in_tag,   | in
//         | in_priority_req, in_now_ms                    |
// out     | out_valid/out_ready, out_status, out_grant_*  | out
// cfg     | cfg_we, cfg_data (aging period)               | in
//
// The pick is a serial scan that compares one flow score per cycle.
// Reset clears all flow state; queue memories need no clearing.
// One item is in flight; a waiting result holds off the next item only
// when it is not taken in the cycle the block returns to idle.
module per_flow_aging_priority_scheduler #(
  parameter int FLOWS      = pfas_pkg::FLOWS_DEF,
  parameter int FIFO_DEPTH = pfas_pkg::FIFO_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pfas_pkg::CMD_W-1:0]    in_cmd,
  input  logic [pfas_pkg::FLOW_W-1:0]   in_flow,
  input  logic [pfas_pkg::TAG_W-1:0]    in_tag,
  input  logic [pfas_pkg::PRI_W-1:0]    in_priority_req,
  input  logic [pfas_pkg::TIME_W-1:0]   in_now_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pfas_pkg::STATUS_W-1:0] out_status,
  output logic [pfas_pkg::FLOW_W-1:0]   out_grant_flow,
  output logic [pfas_pkg::TAG_W-1:0]    out_grant_tag,
  input  logic                          cfg_we,
  input  logic [pfas_pkg::PERIOD_W-1:0] cfg_data
);
  import pfas_pkg::*;

  pfas_cmd_t cmd;
  pfas_sts_t sts;
  logic [STATUS_W-1:0] res_status;
  logic [PERIOD_W-1:0] period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
    end else if (cfg_we) begin
      period_r <= cfg_data;
    end
  end

  pfas_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .out_valid(out_valid), .out_ready(out_ready),
    .cmd(cmd), .sts(sts), .res_status(res_status));

  pfas_datapath #(.FLOWS(FLOWS), .FIFO_DEPTH(FIFO_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_flow(in_flow),
    .in_tag(in_tag), .in_priority_req(in_priority_req), .in_now_ms(in_now_ms),
    .period(period_r), .res_status(res_status), .out_status_r(out_status),
    .out_grant_flow_r(out_grant_flow), .out_grant_tag_r(out_grant_tag));
endmodule

// File: src/pfas_ram.sv
// ----------------------------------------------------------------------------
// pfas_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module pfas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/pfas_datapath.sv
// ----------------------------------------------------------------------------
// pfas_datapath
// Queue memories, per-flow state, score snapshot and serial maximum scan.
// ----------------------------------------------------------------------------
module pfas_datapath #(
  parameter int FLOWS      = pfas_pkg::FLOWS_DEF,
  parameter int FIFO_DEPTH = pfas_pkg::FIFO_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pfas_pkg::pfas_cmd_t               cmd,
  output pfas_pkg::pfas_sts_t               sts,
  input  logic [pfas_pkg::FLOW_W-1:0]       in_flow,
  input  logic [pfas_pkg::TAG_W-1:0]        in_tag,
  input  logic [pfas_pkg::PRI_W-1:0]        in_priority_req,
  input  logic [pfas_pkg::TIME_W-1:0]       in_now_ms,
  input  logic [pfas_pkg::PERIOD_W-1:0]     period,
  input  logic [pfas_pkg::STATUS_W-1:0]     res_status,
  output logic [pfas_pkg::STATUS_W-1:0]     out_status_r,
  output logic [pfas_pkg::FLOW_W-1:0]       out_grant_flow_r,
  output logic [pfas_pkg::TAG_W-1:0]        out_grant_tag_r
);
  import pfas_pkg::*;

  localparam int FI_W  = (FLOWS > 1) ? $clog2(FLOWS) : 1;
  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int MEM_D = FLOWS * FIFO_DEPTH;
  localparam int MA_W  = $clog2(MEM_D);

  logic [FLOW_W-1:0] flow_r;
  logic [TAG_W-1:0]  tag_r;
  logic [PRI_W-1:0]  pri_r;
  logic [TIME_W-1:0] now_r;

  logic [PTR_W-1:0] head_r   [FLOWS];
  logic [CNT_W-1:0] count_r  [FLOWS];
  logic             active_r [FLOWS];
  logic             cvalid_r [FLOWS];
  logic [SCORE_W-1:0] cscore_r [FLOWS];

  logic [FI_W-1:0]    scan_r;
  logic [FI_W-1:0]    best_r;
  logic [SCORE_W-1:0] bscore_r;
  logic               found_r;

  logic [FI_W-1:0]  fi;
  logic             in_rng;
  logic [PTR_W-1:0] tail_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [FI_W-1:0]  rd_flow;
  logic [MA_W-1:0]  waddr, raddr;
  logic             we;
  logic [TAG_W-1:0]  rd_tag;
  logic [PRI_W-1:0]  rd_pri;
  logic [TIME_W-1:0] rd_time;
  logic [TIME_W-1:0] wait_full;
  logic [WAIT_W-1:0] wait_sat;
  logic [SCORE_W-1:0] prod_r;
  logic [WAIT_W-1:0]  wait_r;

  // Sum stays below twice the depth, so one conditional subtract wraps it.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] n);
    logic [CNT_W+PTR_W:0] s;
    s = {{(CNT_W+1){1'b0}}, p} + {{(PTR_W+1){1'b0}}, n};
    if (s >= (CNT_W+PTR_W+1)'(FIFO_DEPTH)) begin
      s = s - (CNT_W+PTR_W+1)'(FIFO_DEPTH);
    end
    return PTR_W'(s);
  endfunction

  assign fi     = FI_W'(flow_r);
  assign in_rng = ({{(32-FLOW_W){1'b0}}, flow_r} < 32'(FLOWS));
  assign tail_ptr = ptr_inc(head_r[fi], count_r[fi]);
  assign rd_flow  = cmd.rd_best ? best_r : fi;
  assign rd_ptr   = head_r[rd_flow];
  assign we       = cmd.rd_tail;
  assign waddr    = MA_W'(fi * FIFO_DEPTH + tail_ptr);
  assign raddr    = MA_W'(rd_flow * FIFO_DEPTH + rd_ptr);

  pfas_ram #(.WIDTH(TAG_W), .DEPTH(MEM_D)) u_tag (
    .clk(clk), .we(we), .waddr(waddr), .wdata(tag_r), .raddr(raddr), .rdata(rd_tag));
  pfas_ram #(.WIDTH(PRI_W), .DEPTH(MEM_D)) u_pri (
    .clk(clk), .we(we), .waddr(waddr), .wdata(pri_r), .raddr(raddr), .rdata(rd_pri));
  pfas_ram #(.WIDTH(TIME_W), .DEPTH(MEM_D)) u_time (
    .clk(clk), .we(we), .waddr(waddr), .wdata(now_r), .raddr(raddr), .rdata(rd_time));

  assign wait_full = now_r - rd_time;
  assign wait_sat  = (wait_full > TIME_W'({WAIT_W{1'b1}})) ? {WAIT_W{1'b1}}
                                                            : wait_full[WAIT_W-1:0];

  assign sts.full      = !in_rng || (count_r[fi] >= CNT_W'(FIFO_DEPTH));
  assign sts.in_range  = in_rng;
  assign sts.scan_last = (scan_r == FI_W'(FLOWS - 1));
  assign sts.found     = found_r;

  // Product registered in the read-data cycle, added in the snapshot cycle.
  always_ff @(posedge clk) begin
    prod_r <= SCORE_W'(rd_pri) * SCORE_W'(period);
    wait_r <= wait_sat;
    if (cmd.load) begin
      flow_r <= in_flow;
      tag_r  <= in_tag;
      pri_r  <= in_priority_req;
      now_r  <= in_now_ms;
    end
    if (cmd.done) begin
      out_status_r     <= res_status;
      out_grant_flow_r <= (cmd.grant) ? FLOW_W'(best_r) : '0;
      out_grant_tag_r  <= (cmd.grant) ? rd_tag : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FLOWS; i++) begin
        head_r[i]   <= '0;
        count_r[i]  <= '0;
        active_r[i] <= 1'b0;
        cvalid_r[i] <= 1'b0;
        cscore_r[i] <= '0;
      end
      scan_r   <= '0;
      best_r   <= '0;
      bscore_r <= '0;
      found_r  <= 1'b0;
    end else begin
      if (cmd.rd_tail) begin
        count_r[fi] <= count_r[fi] + 1'b1;
      end
      if (cmd.rel) begin
        active_r[fi] <= 1'b0;
      end
      if (cmd.snap) begin
        // count and active are already updated here
        if (active_r[fi] || count_r[fi] == '0) begin
          cvalid_r[fi] <= 1'b0;
        end else begin
          cvalid_r[fi] <= 1'b1;
          cscore_r[fi] <= prod_r + SCORE_W'(wait_r);
        end
      end
      if (cmd.scan_clr) begin
        scan_r  <= '0;
        found_r <= 1'b0;
        best_r  <= '0;
      end
      if (cmd.scan_step) begin
        if (cvalid_r[scan_r] && (!found_r || cscore_r[scan_r] > bscore_r)) begin
          found_r  <= 1'b1;
          best_r   <= scan_r;
          bscore_r <= cscore_r[scan_r];
        end
        if (!sts.scan_last) begin
          scan_r <= scan_r + 1'b1;
        end
      end
      if (cmd.grant) begin
        head_r[best_r]   <= ptr_inc(head_r[best_r], CNT_W'(1));
        if (count_r[best_r] != '0) begin
          count_r[best_r] <= count_r[best_r] - 1'b1;
        end
        active_r[best_r] <= 1'b1;
        cvalid_r[best_r] <= 1'b0;
      end
    end
  end
endmodule

// File: src/pfas_ctrl.sv
// ----------------------------------------------------------------------------
// pfas_ctrl
// Command sequencer: handshake, enqueue, pick scan and release steps.
// ----------------------------------------------------------------------------
module pfas_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pfas_pkg::CMD_W-1:0]    in_cmd,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pfas_pkg::pfas_cmd_t           cmd,
  input  pfas_pkg::pfas_sts_t           sts,
  output logic [pfas_pkg::STATUS_W-1:0] res_status
);
  import pfas_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_ENQ_W, S_RD, S_RDW, S_SNAP, S_SCAN, S_BEST, S_BESTW, S_GRANT, S_NONE
  } state_t;

  state_t state_r, state_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    res_status    = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          cmd_nxt   = in_cmd;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (cmd_r)
          CMD_ENQ: begin
            if (sts.full) begin
              res_status = ST_FULL;
              cmd.done = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              cmd.rd_tail = 1'b1;
              state_nxt = S_ENQ_W;
            end
          end
          CMD_PICK: begin
            cmd.scan_clr = 1'b1;
            state_nxt = S_SCAN;
          end
          CMD_REL: begin
            if (sts.in_range) begin
              cmd.rel = 1'b1;
              state_nxt = S_RD;
            end else begin
              cmd.done = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          default: begin
            cmd.done = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_ENQ_W: state_nxt = S_RD; // let the write land before the head read
      S_RD: begin
        cmd.rd_head = 1'b1;
        state_nxt = S_RDW;
      end
      S_RDW: state_nxt = S_SNAP;
      S_SNAP: begin
        cmd.snap = 1'b1;
        cmd.done = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_BEST;
        end
      end
      S_BEST: state_nxt = sts.found ? S_BESTW : S_NONE;
      S_BESTW: begin
        cmd.rd_best = 1'b1;
        state_nxt = S_GRANT;
      end
      S_GRANT: begin
        cmd.grant = 1'b1;
        cmd.done = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_NONE: begin
        res_status = ST_NONE;
        cmd.done = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmd_r       <= CMD_ENQ;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

// File: src/pfas_checker.sv
// ----------------------------------------------------------------------------
// pfas_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "per_flow_aging_priority_scheduler_assert.svh"

module pfas_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pfas_pkg::STATUS_W-1:0] out_status,
  input logic [pfas_pkg::FLOW_W-1:0]   out_grant_flow,
  input logic [pfas_pkg::TAG_W-1:0]    out_grant_tag
);
  import pfas_pkg::*;

  `PFS_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "busy after transfer")
  `PFS_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, out_status != 2'd3, "bad status code")
  `PFS_ASSERT_IMP(a_no_grant_zero, clk, rst_n, out_valid && out_status != ST_OK, out_grant_flow == '0 && out_grant_tag == '0, "grant on failure")
  `PFS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status), "result dropped")
endmodule

bind per_flow_aging_priority_scheduler pfas_checker u_pfas_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_grant_flow(out_grant_flow), .out_grant_tag(out_grant_tag));
